/* sv/nonpreemptive_priority_scheduler_core_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the priority scheduler core
// Shared wrappers around concurrent assertions, clocked and reset-gated.
// ----------------------------------------------------------------------------
`ifndef NONPREEMPTIVE_PRIORITY_SCHEDULER_CORE_DEFINES_SVH
`define NONPREEMPTIVE_PRIORITY_SCHEDULER_CORE_DEFINES_SVH

// condition holds at every edge out of reset
`define NPS_ASSERT_HOLDS(name, clk, rst, cond) \
   name: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("invariant violated");

// same-cycle implication
`define NPS_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication violated");

// next-cycle implication
`define NPS_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`endif

/* sv/npsch_pkg.sv */
// ----------------------------------------------------------------------------
// npsch_pkg
// Types and fixed widths shared by the priority scheduler modules.
// ----------------------------------------------------------------------------
package npsch_pkg;

   localparam int ARR_W   = 16;
   localparam int BURST_W = 16;
   localparam int PRIO_W  = 8;
   localparam int TIME_W  = 21;
   localparam int ID_W    = 4;

   typedef logic [TIME_W-1:0] time_type;

   typedef struct packed {
      logic [ARR_W-1:0]   arrival;
      logic [BURST_W-1:0] burst;
      logic [PRIO_W-1:0]  prio;
   } job_entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CALC,
      ST_EMIT
   } state_type;

endpackage

/* sv/npsch_store.sv */
// ----------------------------------------------------------------------------
// npsch_store
// Job table: one write port for loading, one registered read port for scans.
// ----------------------------------------------------------------------------
module npsch_store #(
   parameter int DEPTH = 16,
   parameter int IDX_W = 4
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [IDX_W-1:0]          wr_addr,
   input  npsch_pkg::job_entry_type  wr_data,
   input  logic [IDX_W-1:0]          rd_addr,
   output npsch_pkg::job_entry_type  rd_data
);

   npsch_pkg::job_entry_type mem [DEPTH];
   npsch_pkg::job_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/npsch_scan.sv */
// ----------------------------------------------------------------------------
// npsch_scan
// Shared compare unit: one table entry per cycle, tracks two candidates.
// ----------------------------------------------------------------------------
module npsch_scan #(
   parameter int IDX_W = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      clear,
   input  logic                      ent_valid,
   input  npsch_pkg::job_entry_type  ent,
   input  logic [IDX_W-1:0]          ent_id,
   input  npsch_pkg::time_type       cur_time,
   input  logic                      first_pick,
   output logic                      pick_found,
   output npsch_pkg::job_entry_type  pick_entry,
   output logic [IDX_W-1:0]          pick_id,
   output npsch_pkg::time_type       pick_start
);

   // best among jobs already arrived: priority, then arrival, then id
   logic                      have_arr_ff, have_arr_in;
   npsch_pkg::job_entry_type  arr_best_ff, arr_best_in;
   logic [IDX_W-1:0]          arr_id_ff, arr_id_in;
   // earliest remaining job: arrival, then priority, then id
   logic                      have_early_ff, have_early_in;
   npsch_pkg::job_entry_type  early_best_ff, early_best_in;
   logic [IDX_W-1:0]          early_id_ff, early_id_in;

   logic arrived;
   logic arr_better;
   logic early_better;
   logic use_early;

   // entries come in rising id order, so equal keys keep the earlier holder
   assign arrived = npsch_pkg::time_type'(ent.arrival) <= cur_time;
   assign arr_better = !have_arr_ff || (ent.prio < arr_best_ff.prio) ||
                       ((ent.prio == arr_best_ff.prio) &&
                        (ent.arrival < arr_best_ff.arrival));
   assign early_better = !have_early_ff || (ent.arrival < early_best_ff.arrival) ||
                         ((ent.arrival == early_best_ff.arrival) &&
                          (ent.prio < early_best_ff.prio));

   always_comb begin
      have_arr_in   = have_arr_ff;
      arr_best_in   = arr_best_ff;
      arr_id_in     = arr_id_ff;
      have_early_in = have_early_ff;
      early_best_in = early_best_ff;
      early_id_in   = early_id_ff;
      if (clear) begin
         have_arr_in   = 1'b0;
         have_early_in = 1'b0;
      end else if (ent_valid) begin
         if (arrived && arr_better) begin
            have_arr_in = 1'b1;
            arr_best_in = ent;
            arr_id_in   = ent_id;
         end
         if (early_better) begin
            have_early_in = 1'b1;
            early_best_in = ent;
            early_id_in   = ent_id;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_arr_ff   <= 1'b0;
         have_early_ff <= 1'b0;
      end else begin
         have_arr_ff   <= have_arr_in;
         have_early_ff <= have_early_in;
      end
   end

   always_ff @(posedge clock) begin
      arr_best_ff   <= arr_best_in;
      arr_id_ff     <= arr_id_in;
      early_best_ff <= early_best_in;
      early_id_ff   <= early_id_in;
   end

   // nothing arrived yet (or first pick): clock jumps to earliest arrival
   assign use_early  = first_pick || !have_arr_ff;
   assign pick_found = have_early_ff;
   assign pick_entry = use_early ? early_best_ff : arr_best_ff;
   assign pick_id    = use_early ? early_id_ff : arr_id_ff;
   assign pick_start = use_early ? npsch_pkg::time_type'(early_best_ff.arrival) : cur_time;

endmodule

/* sv/nonpreemptive_priority_scheduler_core.sv */
// ----------------------------------------------------------------------------
// nonpreemptive_priority_scheduler_core
// Loads a set of jobs, then emits a non-preemptive priority schedule.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one job per item (arrival, burst, priority, last_job).
//   A job is taken while req_stall is low and stored under the next id; jobs beyond
//   MAX_JOBS are dropped and flagged on every result of that set.
//   The item with last_job set closes the set and starts scheduling; req_stall
//   stays high until the last result has been loaded into the output register.
//   rsp_* gives one item per job in run order: id, completion, turnaround,
//   waiting time, the overflow flag and last_result on the final job.
// Timing:
//   Each pick scans the n stored jobs through one registered table read port
//   and one compare unit, does the arithmetic in ST_CALC and then loads the
//   output in ST_EMIT, waiting there while the output register is stalled.
//   Loading takes one job per cycle while req_stall is low.
// Reset clears the set, the done bits and the schedule clock; the job table
//   itself is not cleared. A stalled result holds in the output register and
//   the sequencer waits, so no result is lost or repeated.
// ----------------------------------------------------------------------------
`include "nonpreemptive_priority_scheduler_core_defines.svh"

module nonpreemptive_priority_scheduler_core #(
   parameter int MAX_JOBS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [15:0]  req_arrival_time,
   input  logic [15:0]  req_burst_time,
   input  logic [7:0]   req_job_priority,
   input  logic         req_last_job,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [3:0]   rsp_job_id,
   output logic [20:0]  rsp_completion_time,
   output logic [20:0]  rsp_turnaround_time,
   output logic [20:0]  rsp_waiting_time,
   output logic         rsp_overflow,
   output logic         rsp_last_result
);

   localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
   localparam int CNT_W = $clog2(MAX_JOBS + 1);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_JOBS);

   npsch_pkg::state_type state_ff, state_in;

   logic [CNT_W-1:0]    count_ff, count_in;
   logic                dropped_ff, dropped_in;
   logic [CNT_W-1:0]    n_ff, n_in;
   logic [CNT_W-1:0]    k_ff, k_in;
   logic [CNT_W-1:0]    scan_idx_ff, scan_idx_in;
   logic [MAX_JOBS-1:0] done_ff, done_in;
   npsch_pkg::time_type cur_time_ff, cur_time_in;
   npsch_pkg::time_type comp_ff, comp_in;
   npsch_pkg::time_type wait_ff, wait_in;

   logic                rd_valid_ff, rd_valid_in;
   logic                rd_last_ff, rd_last_in;
   logic [IDX_W-1:0]    rd_idx_ff, rd_idx_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [3:0]          rsp_job_id_ff, rsp_job_id_in;
   npsch_pkg::time_type rsp_comp_ff, rsp_comp_in;
   npsch_pkg::time_type rsp_turn_ff, rsp_turn_in;
   npsch_pkg::time_type rsp_wait_ff, rsp_wait_in;
   logic                rsp_ovf_ff, rsp_ovf_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                      req_accept;
   logic                      store_wr;
   npsch_pkg::job_entry_type  wr_entry;
   npsch_pkg::job_entry_type  rd_entry;
   logic                      issue;
   logic                      scan_end;
   logic                      out_free;
   logic                      emit_go;
   logic                      final_pick;
   logic                      scan_clear;
   logic                      ent_valid;
   logic                      pick_found;
   npsch_pkg::job_entry_type  pick_entry;
   logic [IDX_W-1:0]          pick_id;
   npsch_pkg::time_type       pick_start;

   assign req_stall  = (state_ff != npsch_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign store_wr   = req_accept && (count_ff < MAX_CNT);
   assign wr_entry   = '{arrival: req_arrival_time, burst: req_burst_time,
                         prio: req_job_priority};

   assign issue      = (state_ff == npsch_pkg::ST_SCAN) && (scan_idx_ff < n_ff);
   assign scan_end   = rd_valid_ff && rd_last_ff;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign emit_go    = (state_ff == npsch_pkg::ST_EMIT) && out_free;
   assign final_pick = (k_ff == (n_ff - 1'b1));
   assign scan_clear = (req_accept && req_last_job) || (emit_go && !final_pick);
   assign ent_valid  = rd_valid_ff && !done_ff[rd_idx_ff];

   assign rd_valid_in = issue;
   assign rd_last_in  = (scan_idx_ff == (n_ff - 1'b1));
   assign rd_idx_in   = scan_idx_ff[IDX_W-1:0];

   npsch_store #(
      .DEPTH (MAX_JOBS),
      .IDX_W (IDX_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_wr),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (wr_entry),
      .rd_addr (scan_idx_ff[IDX_W-1:0]),
      .rd_data (rd_entry)
   );

   npsch_scan #(
      .IDX_W (IDX_W)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .clear      (scan_clear),
      .ent_valid  (ent_valid),
      .ent        (rd_entry),
      .ent_id     (rd_idx_ff),
      .cur_time   (cur_time_ff),
      .first_pick (k_ff == '0),
      .pick_found (pick_found),
      .pick_entry (pick_entry),
      .pick_id    (pick_id),
      .pick_start (pick_start)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         npsch_pkg::ST_IDLE: begin
            if (req_accept && req_last_job) begin
               state_in = npsch_pkg::ST_SCAN;
            end
         end
         npsch_pkg::ST_SCAN: begin
            if (scan_end) begin
               state_in = npsch_pkg::ST_CALC;
            end
         end
         npsch_pkg::ST_CALC: begin
            state_in = npsch_pkg::ST_EMIT;
         end
         npsch_pkg::ST_EMIT: begin
            if (out_free) begin
               state_in = final_pick ? npsch_pkg::ST_IDLE : npsch_pkg::ST_SCAN;
            end
         end
         default: begin
            state_in = npsch_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      count_in      = count_ff;
      dropped_in    = dropped_ff;
      n_in          = n_ff;
      k_in          = k_ff;
      scan_idx_in   = scan_idx_ff;
      done_in       = done_ff;
      cur_time_in   = cur_time_ff;
      comp_in       = comp_ff;
      wait_in       = wait_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_job_id_in = rsp_job_id_ff;
      rsp_comp_in   = rsp_comp_ff;
      rsp_turn_in   = rsp_turn_ff;
      rsp_wait_in   = rsp_wait_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         npsch_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (count_ff < MAX_CNT) begin
                  count_in = count_ff + 1'b1;
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_last_job) begin
                  n_in        = count_in;
                  k_in        = '0;
                  scan_idx_in = '0;
               end
            end
         end
         npsch_pkg::ST_SCAN: begin
            if (issue) begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end
         npsch_pkg::ST_CALC: begin
            comp_in = pick_start + npsch_pkg::time_type'(pick_entry.burst);
            wait_in = pick_start - npsch_pkg::time_type'(pick_entry.arrival);
            cur_time_in = comp_in;
            done_in[pick_id] = 1'b1;
         end
         npsch_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_job_id_in = 4'(pick_id);
               rsp_comp_in   = comp_ff;
               rsp_turn_in   = comp_ff - npsch_pkg::time_type'(pick_entry.arrival);
               rsp_wait_in   = wait_ff;
               rsp_ovf_in    = dropped_ff;
               rsp_last_in   = final_pick;
               k_in          = k_ff + 1'b1;
               scan_idx_in   = '0;
               if (final_pick) begin
                  count_in   = '0;
                  dropped_in = 1'b0;
                  done_in    = '0;
               end
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && rsp_stall;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= npsch_pkg::ST_IDLE;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         n_ff         <= '0;
         k_ff         <= '0;
         scan_idx_ff  <= '0;
         done_ff      <= '0;
         cur_time_ff  <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         n_ff         <= n_in;
         k_ff         <= k_in;
         scan_idx_ff  <= scan_idx_in;
         done_ff      <= done_in;
         cur_time_ff  <= cur_time_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_last_ff    <= rd_last_in;
      rd_idx_ff     <= rd_idx_in;
      comp_ff       <= comp_in;
      wait_ff       <= wait_in;
      rsp_job_id_ff <= rsp_job_id_in;
      rsp_comp_ff   <= rsp_comp_in;
      rsp_turn_ff   <= rsp_turn_in;
      rsp_wait_ff   <= rsp_wait_in;
      rsp_ovf_ff    <= rsp_ovf_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_job_id          = rsp_job_id_ff;
   assign rsp_completion_time = rsp_comp_ff;
   assign rsp_turnaround_time = rsp_turn_ff;
   assign rsp_waiting_time    = rsp_wait_ff;
   assign rsp_overflow        = rsp_ovf_ff;
   assign rsp_last_result     = rsp_last_ff;

   `NPS_ASSERT_HOLDS(a_count_bound, clock, reset, count_ff <= MAX_CNT)
   `NPS_ASSERT_IMPL(a_idle_clean, clock, reset, state_ff == npsch_pkg::ST_IDLE, done_ff == '0)
   `NPS_ASSERT_IMPL(a_pick_found, clock, reset, state_ff == npsch_pkg::ST_CALC, pick_found)
   `NPS_ASSERT_IMPL(a_pick_in_set, clock, reset, state_ff != npsch_pkg::ST_IDLE, k_ff < n_ff)
   `NPS_ASSERT_NEXT(a_emit_loads, clock, reset, emit_go, rsp_valid_ff)

endmodule

/* sim/tb_nonpreemptive_priority_scheduler_core.sv */
// -----------------------------------------------------------------------------
// tb_nonpreemptive_priority_scheduler_core
// Feeds job sets into the scheduler core with random gaps on the request side
// and random and long stalls on the result side. An in-bench priority schedule predicts every result item, and
// each item the core emits is compared field by field, in order.
// -----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_nonpreemptive_priority_scheduler_core;

   localparam int MAX_JOBS       = 16;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int TAIL_CYCLES    = 40;
   localparam int RANDOM_JOBS    = 137;

   typedef enum int {
      PHASE_SLOW_SINK,
      PHASE_SLOW_SOURCE,
      PHASE_FULL_RATE
   } idle_phase_type;

   typedef struct {
      logic [npsch_pkg::ARR_W-1:0]   arrival;
      logic [npsch_pkg::BURST_W-1:0] burst;
      logic [npsch_pkg::PRIO_W-1:0]  prio;
      logic                          last;
      idle_phase_type                phase;
      bit                            drain;   // hold this item until all results are in
      bit                            hold;    // start a long receiver hold-off once sent
   } job_item_type;

   typedef struct {
      logic [npsch_pkg::ID_W-1:0] id;
      npsch_pkg::time_type        completion;
      npsch_pkg::time_type        turnaround;
      npsch_pkg::time_type        waiting;
      logic                       overflow;
      logic                       last;
   } sched_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [15:0]         req_arrival_time = '0;
   logic [15:0]         req_burst_time = '0;
   logic [7:0]          req_job_priority = '0;
   logic                req_last_job = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [3:0]          rsp_job_id;
   logic [20:0]         rsp_completion_time;
   logic [20:0]         rsp_turnaround_time;
   logic [20:0]         rsp_waiting_time;
   logic                rsp_overflow;
   logic                rsp_last_result;

   job_item_type        pending_jobs[$];
   sched_result_type    expected_schedule[$];

   // predictor state
   npsch_pkg::job_entry_type job_table[MAX_JOBS];
   int                  jobs_loaded = 0;
   bit                  set_overflowed = 1'b0;
   npsch_pkg::time_type sched_clock = '0;

   idle_phase_type      gen_phase = PHASE_SLOW_SINK;
   bit                  gen_drain = 1'b0;
   idle_phase_type      send_phase = PHASE_SLOW_SINK;
   int                  hold_requests = 0;
   int                  hold_seen = 0;
   int                  hold_left = 0;
   bit                  in_fire = 1'b0;
   int                  quiet_cycles = 0;
   int                  error_count = 0;

   nonpreemptive_priority_scheduler_core #(
      .MAX_JOBS(MAX_JOBS)
   ) u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_arrival_time    (req_arrival_time),
      .req_burst_time      (req_burst_time),
      .req_job_priority    (req_job_priority),
      .req_last_job        (req_last_job),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_job_id          (rsp_job_id),
      .rsp_completion_time (rsp_completion_time),
      .rsp_turnaround_time (rsp_turnaround_time),
      .rsp_waiting_time    (rsp_waiting_time),
      .rsp_overflow        (rsp_overflow),
      .rsp_last_result     (rsp_last_result)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int idle_percent(idle_phase_type phase, bit for_sender);
      case (phase)
         PHASE_SLOW_SINK:   return for_sender ? 18 : 83;
         PHASE_SLOW_SOURCE: return for_sender ? 83 : 18;
         default:           return 0;
      endcase
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("ERROR @%0t: %s got %0d expected %0d", $time, what, got, want);
      error_count++;
   endtask

   task automatic queue_job(input int arrival, input int burst, input int prio,
                            input bit last);
      job_item_type item;
      item.arrival = arrival[npsch_pkg::ARR_W-1:0];
      item.burst   = burst[npsch_pkg::BURST_W-1:0];
      item.prio    = prio[npsch_pkg::PRIO_W-1:0];
      item.last    = last;
      item.phase   = gen_phase;
      item.drain   = gen_drain;
      item.hold    = 1'b0;
      gen_drain = 1'b0;
      pending_jobs.push_back(item);
   endtask

   // set sizes lean small; a few full and overfull sets
   task automatic queue_random_set(output int n_jobs);
      int  sel;
      bit  wide_arr, wide_burst, wide_prio;
      sel = $urandom_range(99);
      if (sel < 65)      n_jobs = $urandom_range(5, 1);
      else if (sel < 88) n_jobs = $urandom_range(MAX_JOBS - 1, 6);
      else if (sel < 95) n_jobs = MAX_JOBS;
      else               n_jobs = $urandom_range(MAX_JOBS + 3, MAX_JOBS + 1);
      wide_arr   = 1'($urandom_range(1));
      wide_burst = 1'($urandom_range(1));
      wide_prio  = 1'($urandom_range(1));
      for (int i = 0; i < n_jobs; i++) begin
         queue_job(wide_arr   ? $urandom_range(65535) : $urandom_range(63),
                   wide_burst ? $urandom_range(65535) : $urandom_range(15),
                   wide_prio  ? $urandom_range(255)   : $urandom_range(3),
                   i == n_jobs - 1);
      end
   endtask

   function automatic bit runs_first(int a, int b);
      if (job_table[a].prio != job_table[b].prio)
         return job_table[a].prio < job_table[b].prio;
      if (job_table[a].arrival != job_table[b].arrival)
         return job_table[a].arrival < job_table[b].arrival;
      return a < b;
   endfunction

   task automatic build_schedule();
      logic [MAX_JOBS-1:0] scheduled;
      int                  pick;
      npsch_pkg::time_type earliest;
      sched_result_type    res;
      scheduled = '0;
      for (int k = 0; k < jobs_loaded; k++) begin
         earliest = '1;
         for (int i = 0; i < jobs_loaded; i++) begin
            if (!scheduled[i] &&
                npsch_pkg::time_type'(job_table[i].arrival) < earliest)
               earliest = npsch_pkg::time_type'(job_table[i].arrival);
         end
         // idle gap: clock jumps forward to the next arrival
         if (k == 0 || earliest > sched_clock) sched_clock = earliest;
         pick = -1;
         for (int i = 0; i < jobs_loaded; i++) begin
            if (!scheduled[i] &&
                npsch_pkg::time_type'(job_table[i].arrival) <= sched_clock &&
                (pick < 0 || runs_first(i, pick)))
               pick = i;
         end
         scheduled[pick] = 1'b1;
         res.id         = pick[npsch_pkg::ID_W-1:0];
         res.completion = sched_clock + npsch_pkg::time_type'(job_table[pick].burst);
         sched_clock    = res.completion;
         res.turnaround = res.completion - npsch_pkg::time_type'(job_table[pick].arrival);
         res.waiting    = res.turnaround - npsch_pkg::time_type'(job_table[pick].burst);
         res.overflow   = set_overflowed;
         res.last       = (k == jobs_loaded - 1);
         expected_schedule.push_back(res);
      end
   endtask

   task automatic load_job(input logic [15:0] arrival, input logic [15:0] burst,
                           input logic [7:0] prio, input logic last);
      if (jobs_loaded < MAX_JOBS) begin
         job_table[jobs_loaded].arrival = arrival;
         job_table[jobs_loaded].burst   = burst;
         job_table[jobs_loaded].prio    = prio;
         jobs_loaded++;
      end else begin
         set_overflowed = 1'b1;
      end
      if (last) begin
         build_schedule();
         jobs_loaded    = 0;
         set_overflowed = 1'b0;
      end
   endtask

   task automatic check_result(input sched_result_type got);
      sched_result_type want;
      if (expected_schedule.size() == 0) begin
         report_mismatch("result item with none pending, job_id", int'(got.id), -1);
         return;
      end
      want = expected_schedule.pop_front();
      if (got.id !== want.id)
         report_mismatch("job_id", int'(got.id), int'(want.id));
      if (got.completion !== want.completion)
         report_mismatch("completion_time", int'(got.completion), int'(want.completion));
      if (got.turnaround !== want.turnaround)
         report_mismatch("turnaround_time", int'(got.turnaround), int'(want.turnaround));
      if (got.waiting !== want.waiting)
         report_mismatch("waiting_time", int'(got.waiting), int'(want.waiting));
      if (got.overflow !== want.overflow)
         report_mismatch("overflow", int'(got.overflow), int'(want.overflow));
      if (got.last !== want.last)
         report_mismatch("last_result", int'(got.last), int'(want.last));
   endtask

   // job driver
   always @(negedge clock) begin
      job_item_type nxt;
      bit           go;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || in_fire) begin
         go = pending_jobs.size() != 0;
         if (go) go = $urandom_range(99) >= idle_percent(pending_jobs[0].phase, 1'b1);
         if (go && pending_jobs[0].drain && expected_schedule.size() != 0) go = 1'b0;
         if (go) begin
            nxt = pending_jobs.pop_front();
            req_valid        <= 1'b1;
            req_arrival_time <= nxt.arrival;
            req_burst_time   <= nxt.burst;
            req_job_priority <= nxt.prio;
            req_last_job     <= nxt.last;
            send_phase       <= nxt.phase;
            if (nxt.hold) hold_requests <= hold_requests + 1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result receiver
   always @(negedge clock) begin
      if (hold_seen != hold_requests) begin
         hold_seen = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= $urandom_range(99) < idle_percent(send_phase, 1'b0);
      end
   end

   // monitor
   always @(posedge clock) begin
      sched_result_type got;
      if (reset) begin
         in_fire = 1'b0;
      end else begin
         in_fire = req_valid && !req_stall;
         if (in_fire)
            load_job(req_arrival_time, req_burst_time, req_job_priority, req_last_job);
         if (rsp_valid && !rsp_stall) begin
            got.id         = rsp_job_id;
            got.completion = rsp_completion_time;
            got.turnaround = rsp_turnaround_time;
            got.waiting    = rsp_waiting_time;
            got.overflow   = rsp_overflow;
            got.last       = rsp_last_result;
            check_result(got);
         end
         if (in_fire || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
      end
   end

   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("ERROR @%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("tb: failure");
      $finish;
   end

   initial begin
      int random_jobs;
      int set_size;
      random_jobs = 0;

      // single job at the top of every field
      queue_job(65535, 65535, 255, 1'b1);
      // single job at zero
      queue_job(0, 0, 0, 1'b1);
      // idle gaps, priority tie broken by id, zero burst
      queue_job(10, 5, 3, 1'b0);
      queue_job(100, 2, 1, 1'b0);
      queue_job(10, 1, 3, 1'b0);
      queue_job(5, 0, 3, 1'b1);
      // full set plus a dropped job that carries last_job; longest times
      for (int i = 0; i <= MAX_JOBS; i++)
         queue_job((i % 2) ? 65535 : 0, 65535 - i, i % 3, i == MAX_JOBS);
      pending_jobs[pending_jobs.size() - 1].hold = 1'b1;

      while (random_jobs < RANDOM_JOBS) begin
         if (random_jobs >= 2 * RANDOM_JOBS / 3 && gen_phase != PHASE_FULL_RATE) begin
            gen_phase = PHASE_FULL_RATE;
            gen_drain = 1'b1;
         end else if (random_jobs >= RANDOM_JOBS / 3 && gen_phase == PHASE_SLOW_SINK) begin
            gen_phase = PHASE_SLOW_SOURCE;
            gen_drain = 1'b1;
         end
         queue_random_set(set_size);
         random_jobs += set_size;
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_jobs.size() != 0 || req_valid) @(posedge clock);
      while (expected_schedule.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      while (expected_schedule.size() != 0) begin
         report_mismatch("missing result item, job_id", -1, int'(expected_schedule[0].id));
         void'(expected_schedule.pop_front());
      end
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
